>>> hw/rtl/bol_pkg.sv
// Shared definitions for the bounded ordered list: operation and status codes,
// and the command word broadcast to the storage cells.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package bol_pkg;

  // operation codes carried by in_op
  localparam logic [2:0] OP_APPEND     = 3'd0;
  localparam logic [2:0] OP_INSERT     = 3'd1;
  localparam logic [2:0] OP_GET        = 3'd2;
  localparam logic [2:0] OP_SET        = 3'd3;
  localparam logic [2:0] OP_FIND       = 3'd4;
  localparam logic [2:0] OP_REMOVE_AT  = 3'd5;
  localparam logic [2:0] OP_REMOVE_VAL = 3'd6;
  localparam logic [2:0] OP_CLEAR      = 3'd7;

  // status codes on out_status
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_RANGE   = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;
  localparam logic [1:0] ST_MISSING = 2'd3;

  // what every cell does in the update cycle
  typedef enum logic [1:0] {
    CK_HOLD   = 2'd0,
    CK_INSERT = 2'd1,
    CK_REMOVE = 2'd2,
    CK_WRITE  = 2'd3
  } cell_kind_t;

  typedef struct packed {
    cell_kind_t         kind;
    logic signed [31:0] value;
  } cell_cmd_t;

endpackage

`default_nettype wire

>>> hw/rtl/bounded_ordered_list.sv
// Top level of the bounded ordered list: control sequencer, read mux and the
// row of bol_cell storage cells. Depends on bol_pkg and bol_cell.
`timescale 1ns / 1ps
`default_nettype none

//  channel   handshake          ports
//  -------   ---------          -----
//  input     start & !busy      in_op, in_position_in, in_value_in
//  result    out_valid strobe   out_data_out, out_found_position, out_status,
//                               out_entry_total, out_is_empty
//
//  Each word keeps the block busy until its update cycle in S_APPLY is done,
//  so a new word is taken only after the last one has finished. Find and
//  remove value first walk the cells through the read mux, one cell a cycle,
//  until a match or the end of the list. The result strobe is high for one
//  cycle and cannot be stalled. Synchronous reset empties the list; cell contents are not cleared.

module bounded_ordered_list #(
  parameter int CAPACITY = 16
) (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                start,
  output logic               busy,
  input  wire        [2:0]   in_op,
  input  wire        [4:0]   in_position_in,
  input  wire signed [31:0]  in_value_in,
  output logic               out_valid,
  output logic signed [31:0] out_data_out,
  output logic       [3:0]   out_found_position,
  output logic       [1:0]   out_status,
  output logic       [4:0]   out_entry_total,
  output logic               out_is_empty
);

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int CMP_W = (CNT_W > 5) ? CNT_W : 5;
  localparam logic [CMP_W-1:0] CAP_C = CMP_W'(CAPACITY);
  localparam logic [CMP_W-1:0] ONE_C = CMP_W'(1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_APPLY
  } state_t;

  state_t             state_r;
  logic [2:0]         op_r;
  logic signed [31:0] val_r;
  logic [CMP_W-1:0]   tgt_r;
  logic [CMP_W-1:0]   scan_r;
  logic               miss_r;
  logic [CNT_W-1:0]   count_r;
  logic               out_valid_r;
  logic signed [31:0] out_data_r;
  logic [3:0]         out_found_r;
  logic [1:0]         out_status_r;
  logic [4:0]         out_total_r;
  logic               out_empty_r;

  logic [CMP_W-1:0]   count_ext;
  logic [CMP_W-1:0]   rd_ptr;
  logic signed [31:0] rd_data;
  logic signed [31:0] cell_q [CAPACITY];

  // update-cycle results
  bol_pkg::cell_cmd_t cmd;
  logic [CMP_W-1:0]   apply_tgt;
  logic [1:0]         status_a;
  logic signed [31:0] data_a;
  logic [3:0]         found_a;
  logic [CMP_W-1:0]   count_a;

  assign count_ext = CMP_W'(count_r);
  assign busy      = (state_r != S_IDLE);

  // read mux over the cells: scan pointer while searching, target otherwise
  assign rd_ptr = (state_r == S_SCAN) ? scan_r : tgt_r;

  always_comb begin
    rd_data = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (rd_ptr == CMP_W'(i)) rd_data = cell_q[i];
    end
  end

  // decode the operation in the update cycle
  always_comb begin
    cmd.kind  = bol_pkg::CK_HOLD;
    cmd.value = val_r;
    apply_tgt = tgt_r;
    status_a  = bol_pkg::ST_OK;
    data_a    = '0;
    found_a   = '0;
    count_a   = count_ext;
    unique case (op_r)
      bol_pkg::OP_APPEND: begin
        apply_tgt = count_ext;
        if (count_ext >= CAP_C) begin
          status_a = bol_pkg::ST_FULL;
        end else begin
          cmd.kind = bol_pkg::CK_INSERT;
          count_a  = count_ext + ONE_C;
        end
      end
      bol_pkg::OP_INSERT: begin
        if (tgt_r > count_ext) begin
          status_a = bol_pkg::ST_RANGE;
        end else if (count_ext >= CAP_C) begin
          status_a = bol_pkg::ST_FULL;
        end else begin
          cmd.kind = bol_pkg::CK_INSERT;
          count_a  = count_ext + ONE_C;
        end
      end
      bol_pkg::OP_GET: begin
        if (tgt_r >= count_ext) status_a = bol_pkg::ST_RANGE;
        else data_a = rd_data;
      end
      bol_pkg::OP_SET: begin
        if (tgt_r >= count_ext) status_a = bol_pkg::ST_RANGE;
        else cmd.kind = bol_pkg::CK_WRITE;
      end
      bol_pkg::OP_FIND: begin
        if (miss_r) status_a = bol_pkg::ST_MISSING;
        else found_a = tgt_r[3:0];
      end
      bol_pkg::OP_REMOVE_AT: begin
        if (tgt_r >= count_ext) begin
          status_a = bol_pkg::ST_RANGE;
        end else begin
          data_a   = rd_data;
          cmd.kind = bol_pkg::CK_REMOVE;
          count_a  = count_ext - ONE_C;
        end
      end
      bol_pkg::OP_REMOVE_VAL: begin
        if (miss_r) begin
          status_a = bol_pkg::ST_MISSING;
        end else begin
          data_a   = rd_data;
          cmd.kind = bol_pkg::CK_REMOVE;
          count_a  = count_ext - ONE_C;
        end
      end
      bol_pkg::OP_CLEAR: begin
        count_a = '0;
      end
    endcase
    // cells only move in the update cycle
    if (state_r != S_APPLY) cmd.kind = bol_pkg::CK_HOLD;
  end

  // sequencer with registered result outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (start) begin
            op_r   <= in_op;
            val_r  <= in_value_in;
            tgt_r  <= CMP_W'(in_position_in);
            scan_r <= '0;
            miss_r <= 1'b0;
            if (in_op == bol_pkg::OP_FIND || in_op == bol_pkg::OP_REMOVE_VAL) begin
              state_r <= S_SCAN;
            end else begin
              state_r <= S_APPLY;
            end
          end
        end
        S_SCAN: begin
          if (scan_r >= count_ext) begin
            miss_r  <= 1'b1;
            state_r <= S_APPLY;
          end else if (rd_data == val_r) begin
            tgt_r   <= scan_r;
            state_r <= S_APPLY;
          end else begin
            scan_r <= scan_r + ONE_C;
          end
        end
        S_APPLY: begin
          count_r      <= CNT_W'(count_a);
          out_valid_r  <= 1'b1;
          out_data_r   <= data_a;
          out_found_r  <= found_a;
          out_status_r <= status_a;
          out_total_r  <= count_a[4:0];
          out_empty_r  <= (count_a == '0);
          state_r      <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // row of storage cells, each wired to its neighbors
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic signed [31:0] left_w;
    logic signed [31:0] right_w;
    if (g == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_left
      assign left_w = cell_q[g-1];
    end
    if (g == CAPACITY - 1) begin : g_last
      assign right_w = '0;
    end else begin : g_right
      assign right_w = cell_q[g+1];
    end
    bol_cell #(
      .CMP_W (CMP_W),
      .IDX   (g)
    ) u_cell (
      .clk        (clk),
      .cmd        (cmd),
      .tgt        (apply_tgt),
      .left_data  (left_w),
      .right_data (right_w),
      .data       (cell_q[g])
    );
  end

  assign out_valid          = out_valid_r;
  assign out_data_out       = out_data_r;
  assign out_found_position = out_found_r;
  assign out_status         = out_status_r;
  assign out_entry_total    = out_total_r;
  assign out_is_empty       = out_empty_r;

endmodule

`default_nettype wire

>>> hw/rtl/bol_cell.sv
// One storage cell of the ordered list: holds a single word and takes it
// from its left or right neighbor on insert and remove. Depends on bol_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bol_cell #(
  parameter int CMP_W = 5,
  parameter int IDX   = 0
) (
  input  wire                      clk,
  input  wire bol_pkg::cell_cmd_t  cmd,
  input  wire        [CMP_W-1:0]   tgt,
  input  wire signed [31:0]        left_data,
  input  wire signed [31:0]        right_data,
  output logic signed [31:0]       data
);

  localparam logic [CMP_W-1:0] MY_IDX = CMP_W'(IDX);

  logic signed [31:0] data_r;
  logic signed [31:0] data_nxt;

  // local decision from the broadcast command and this cell's position
  always_comb begin
    data_nxt = data_r;
    case (cmd.kind)
      bol_pkg::CK_INSERT: begin
        if (tgt == MY_IDX) data_nxt = cmd.value;
        else if (MY_IDX > tgt) data_nxt = left_data;
      end
      bol_pkg::CK_REMOVE: begin
        if (MY_IDX >= tgt) data_nxt = right_data;
      end
      bol_pkg::CK_WRITE: begin
        if (tgt == MY_IDX) data_nxt = cmd.value;
      end
      default: data_nxt = data_r;
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data = data_r;

endmodule

`default_nettype wire

>>> dv/tb_bounded_ordered_list.sv
// Testbench for bounded_ordered_list: random and directed list operations are
// driven on the start/busy port, and every strobed result is compared with a
// local model of the list. Depends on bol_pkg and the bounded_ordered_list RTL.
`timescale 1ns / 1ps

module tb_bounded_ordered_list;

  localparam int LIST_DEPTH  = 16;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 40;
  localparam int RANDOM_WORDS = 1800;

  typedef struct packed {
    logic [2:0]         op;
    logic [4:0]         pos;
    logic signed [31:0] value;
  } list_cmd_t;

  typedef struct packed {
    logic signed [31:0] data;
    logic [3:0]         found;
    logic [1:0]         status;
    logic [4:0]         total;
    logic               is_empty;
  } list_result_t;

  typedef enum int {PH_GROW, PH_SHRINK, PH_MIX} mix_phase_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic [2:0]         in_op = bol_pkg::OP_CLEAR;
  logic [4:0]         in_position_in = '0;
  logic signed [31:0] in_value_in = '0;
  logic               out_valid;
  logic signed [31:0] out_data_out;
  logic [3:0]         out_found_position;
  logic [1:0]         out_status;
  logic [4:0]         out_entry_total;
  logic               out_is_empty;

  bounded_ordered_list #(.CAPACITY(LIST_DEPTH)) dut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_op(in_op),
    .in_position_in(in_position_in),
    .in_value_in(in_value_in),
    .out_valid(out_valid),
    .out_data_out(out_data_out),
    .out_found_position(out_found_position),
    .out_status(out_status),
    .out_entry_total(out_entry_total),
    .out_is_empty(out_is_empty)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  list_cmd_t          pending_cmds[$];
  list_result_t       expected_results[$];
  logic signed [31:0] shadow_cells[LIST_DEPTH];
  int                 shadow_len = 0;
  int                 fault_count = 0;
  int                 cycle_count = 0;
  logic               word_taken = 1'b0;

  // close the gap left by the entry at p
  function automatic void drop_entry(input int p);
    for (int i = p; i + 1 < shadow_len; i++)
      shadow_cells[i] = shadow_cells[i + 1];
    shadow_len--;
  endfunction

  // apply one command to the local list and return the result word it gives
  function automatic list_result_t apply_list_op(input list_cmd_t c);
    list_result_t r;
    int hit;
    int p;
    r = '0;
    r.status = bol_pkg::ST_OK;
    p = c.pos;
    hit = -1;
    for (int i = 0; i < shadow_len; i++)
      if (hit < 0 && shadow_cells[i] == c.value) hit = i;
    case (c.op)
      bol_pkg::OP_APPEND: begin
        if (shadow_len >= LIST_DEPTH) r.status = bol_pkg::ST_FULL;
        else begin
          shadow_cells[shadow_len] = c.value;
          shadow_len++;
        end
      end
      bol_pkg::OP_INSERT: begin
        // range test comes before the capacity test
        if (p > shadow_len) r.status = bol_pkg::ST_RANGE;
        else if (shadow_len >= LIST_DEPTH) r.status = bol_pkg::ST_FULL;
        else begin
          for (int i = shadow_len; i > p; i--) shadow_cells[i] = shadow_cells[i - 1];
          shadow_cells[p] = c.value;
          shadow_len++;
        end
      end
      bol_pkg::OP_GET: begin
        if (p >= shadow_len) r.status = bol_pkg::ST_RANGE;
        else r.data = shadow_cells[p];
      end
      bol_pkg::OP_SET: begin
        if (p >= shadow_len) r.status = bol_pkg::ST_RANGE;
        else shadow_cells[p] = c.value;
      end
      bol_pkg::OP_FIND: begin
        if (hit < 0) r.status = bol_pkg::ST_MISSING;
        else r.found = hit[3:0];
      end
      bol_pkg::OP_REMOVE_AT: begin
        if (p >= shadow_len) r.status = bol_pkg::ST_RANGE;
        else begin
          r.data = shadow_cells[p];
          drop_entry(p);
        end
      end
      bol_pkg::OP_REMOVE_VAL: begin
        if (hit < 0) r.status = bol_pkg::ST_MISSING;
        else begin
          r.data = shadow_cells[hit];
          drop_entry(hit);
        end
      end
      default: shadow_len = 0;
    endcase
    r.total = shadow_len[4:0];
    r.is_empty = (shadow_len == 0);
    return r;
  endfunction

  task automatic queue_cmd(input logic [2:0] op, input int pos, input logic [31:0] value);
    list_cmd_t c;
    c.op = op;
    c.pos = pos[4:0];
    c.value = value;
    pending_cmds.push_back(c);
  endtask

  // random command; the phase tilts the op mix so the list fills and drains
  function automatic list_cmd_t random_cmd(input mix_phase_t ph,
                                           input logic [31:0] pool[8]);
    list_cmd_t c;
    int roll;
    roll = $urandom_range(0, 99);
    case (ph)
      PH_GROW:
        c.op = (roll < 40) ? bol_pkg::OP_APPEND : (roll < 70) ? bol_pkg::OP_INSERT :
               3'($urandom_range(2, 6));
      PH_SHRINK:
        c.op = (roll < 30) ? bol_pkg::OP_REMOVE_AT :
               (roll < 60) ? bol_pkg::OP_REMOVE_VAL :
               (roll < 70) ? bol_pkg::OP_APPEND : 3'($urandom_range(1, 4));
      default:
        c.op = (roll < 2) ? bol_pkg::OP_CLEAR : 3'($urandom_range(0, 6));
    endcase
    c.pos = 5'($urandom_range(0, 16));
    // mostly values from a small pool so searches hit, duplicates included
    if ($urandom_range(0, 9) < 7) c.value = pool[$urandom_range(0, 7)];
    else c.value = $urandom;
    return c;
  endfunction

  // stimulus: directed words, then random phases
  initial begin
    logic [31:0] pool[8];
    mix_phase_t ph;
    int phase_left;
    int made;

    queue_cmd(bol_pkg::OP_CLEAR, 0, 32'h0);
    queue_cmd(bol_pkg::OP_GET, 0, 32'h0);
    queue_cmd(bol_pkg::OP_REMOVE_AT, 0, 32'h0);
    queue_cmd(bol_pkg::OP_FIND, 0, 32'h5);
    queue_cmd(bol_pkg::OP_REMOVE_VAL, 0, 32'h5);
    queue_cmd(bol_pkg::OP_SET, 0, 32'h1);
    queue_cmd(bol_pkg::OP_INSERT, 1, 32'h2);
    queue_cmd(bol_pkg::OP_INSERT, 0, 32'h7FFF_FFFF);
    queue_cmd(bol_pkg::OP_APPEND, 0, 32'h8000_0000);
    queue_cmd(bol_pkg::OP_APPEND, 16, 32'hFFFF_FFFF);
    queue_cmd(bol_pkg::OP_INSERT, 3, 32'h0);
    queue_cmd(bol_pkg::OP_INSERT, 1, 32'hA5A5_A5A5);
    queue_cmd(bol_pkg::OP_GET, 4, 32'h0);
    queue_cmd(bol_pkg::OP_GET, 5, 32'h0);
    queue_cmd(bol_pkg::OP_SET, 16, 32'h3);
    queue_cmd(bol_pkg::OP_FIND, 0, 32'hFFFF_FFFF);
    queue_cmd(bol_pkg::OP_FIND, 0, 32'h8000_0000);
    queue_cmd(bol_pkg::OP_APPEND, 0, 32'hFFFF_FFFF);
    queue_cmd(bol_pkg::OP_REMOVE_VAL, 0, 32'hFFFF_FFFF);
    queue_cmd(bol_pkg::OP_REMOVE_AT, 0, 32'h0);
    queue_cmd(bol_pkg::OP_SET, 1, 32'h5A5A_5A5A);
    queue_cmd(bol_pkg::OP_GET, 1, 32'h0);
    queue_cmd(bol_pkg::OP_FIND, 0, 32'h0000_3039);
    queue_cmd(bol_pkg::OP_CLEAR, 0, 32'h0);
    queue_cmd(bol_pkg::OP_GET, 0, 32'h0);

    made = 0;
    phase_left = 0;
    ph = PH_MIX;
    while (made < RANDOM_WORDS) begin
      if (phase_left == 0) begin
        case ($urandom_range(0, 2))
          0: ph = PH_GROW;
          1: ph = PH_SHRINK;
          default: ph = PH_MIX;
        endcase
        phase_left = $urandom_range(30, 110);
        for (int i = 0; i < 8; i++) begin
          case ($urandom_range(0, 5))
            0: pool[i] = 32'h8000_0000;
            1: pool[i] = 32'h7FFF_FFFF;
            2: pool[i] = 32'h0;
            3: pool[i] = 32'hFFFF_FFFF;
            default: pool[i] = $urandom;
          endcase
        end
      end
      pending_cmds.push_back(random_cmd(ph, pool));
      phase_left--;
      made++;
    end
  end

  // reset, then wait for the stimulus to drain and report
  initial begin
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    while (pending_cmds.size() != 0 || start || expected_results.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_results.size() != 0) begin
      $error("%0d result words never arrived", expected_results.size());
      fault_count++;
    end
    if (fault_count == 0)
      $display("bounded_ordered_list verification clean");
    else
      $display("bounded_ordered_list verification failed");
    $finish;
  end

  // driver: present a word at the falling edge, hold it until taken
  int idle_left = 0;
  int burst_left = 0;
  bit burst_run = 1'b0;

  always @(negedge clk) begin
    list_cmd_t c;
    if (rst_n) begin
      if (start && !word_taken) begin
        // still waiting for acceptance
      end else if (idle_left > 0) begin
        start <= 1'b0;
        idle_left--;
      end else if (pending_cmds.size() != 0) begin
        c = pending_cmds.pop_front();
        in_op <= c.op;
        in_position_in <= c.pos;
        in_value_in <= c.value;
        start <= 1'b1;
        // stretches with no idle cycles and stretches with random gaps are picked at random
        if (burst_left == 0) begin
          burst_run = ($urandom_range(0, 3) == 0);
          burst_left = $urandom_range(20, 80);
        end
        burst_left--;
        idle_left = burst_run ? 0 : $urandom_range(0, 8);
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor: predict on acceptance, check each strobed result word
  always @(posedge clk) begin
    list_cmd_t c;
    list_result_t exp_r;
    if (!rst_n) begin
      word_taken <= 1'b0;
    end else begin
      if (out_valid === 1'b1) begin
        if (expected_results.size() == 0) begin
          $error("result word with nothing expected");
          fault_count++;
        end else begin
          exp_r = expected_results.pop_front();
          if (out_data_out !== exp_r.data) begin
            $error("data_out: expected %0d, got %0d", exp_r.data, out_data_out);
            fault_count++;
          end
          if (out_found_position !== exp_r.found) begin
            $error("found_position: expected %0d, got %0d", exp_r.found,
                   out_found_position);
            fault_count++;
          end
          if (out_status !== exp_r.status) begin
            $error("status: expected %0d, got %0d", exp_r.status, out_status);
            fault_count++;
          end
          if (out_entry_total !== exp_r.total) begin
            $error("entry_total: expected %0d, got %0d", exp_r.total,
                   out_entry_total);
            fault_count++;
          end
          if (out_is_empty !== exp_r.is_empty) begin
            $error("is_empty: expected %0d, got %0d", exp_r.is_empty, out_is_empty);
            fault_count++;
          end
        end
      end
      word_taken <= start && !busy;
      if (start && !busy) begin
        c.op = in_op;
        c.pos = in_position_in;
        c.value = in_value_in;
        expected_results.push_back(apply_list_op(c));
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("bounded_ordered_list verification failed");
      $finish;
    end
  end

endmodule
